>>> src/positional_char_list_unit_defines.svh
// Assertion macros for the positional character list unit.
`ifndef POSITIONAL_CHAR_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_CHAR_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcl assertion failed");

// Next-cycle implication, checked outside reset.
`define PCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcl assertion failed");

`endif

>>> src/pcl_pkg.sv
// Shared types and codes for the positional character list unit.
package pcl_pkg;

	// Operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// Width of positions, indexes and counts on the command path
	localparam int POS_W = 8;

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_INSERT,
		JOB_REMOVE,
		JOB_CLEAR
	} pcl_job_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_PUT,
		S_REM_RD,
		S_REM_GRAB,
		S_REM,
		S_DONE
	} pcl_state_t;

	// Decoded command from the front end to the engine
	typedef struct packed {
		logic             start;
		pcl_job_t         job;
		logic [POS_W-1:0] idx;
		logic [7:0]       ch;
		logic [1:0]       status;
	} pcl_cmd_t;

	// Engine status and finished result
	typedef struct packed {
		logic             idle;
		logic             done;
		logic [7:0]       removed;
		logic [1:0]       status;
		logic [POS_W-1:0] count;
	} pcl_rsp_t;

endpackage

>>> src/positional_char_list_unit.sv
// Top level of the positional character list unit: decode, engine and result register.
//
//   channel | handshake            | fields
//   --------+----------------------+------------------------------------
//   request | req_valid, req_stall | operation, char_value, position
//   result  | rsp_valid, rsp_stall | removed_char, status, entry_count
//
// Insert and remove walk the entries between the index and the count before the result, and
// clear, refused or unknown operations go straight to the result. The walk
// over the entry memory moves one entry per cycle through its single write port.
// Reset clears the count; entry contents are only read below the count.
// A stalled result is held in the output register while the engine waits.
module positional_char_list_unit import pcl_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] operation,
	input  logic [7:0] char_value,
	input  logic [7:0] position,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [7:0] removed_char,
	output logic [1:0] status,
	output logic [7:0] entry_count
);

	`include "positional_char_list_unit_defines.svh"

	localparam logic [POS_W-1:0] DEPTH_CNT = POS_W'(DEPTH);

	pcl_cmd_t         cmd;
	pcl_rsp_t         rsp;
	logic             out_free;
	logic             rsp_valid_q;
	logic [7:0]       removed_q;
	logic [1:0]       status_q;
	logic [7:0]       count_q;
	logic [POS_W-1:0] cur_count;
	logic [POS_W-1:0] tgt;

	assign cur_count = rsp.count;
	assign req_stall = !rsp.idle;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Position to index: position one is index 0, zero acts as two
	always_comb begin
		if (position == 8'd1) begin
			tgt = '0;
		end else if (position == 8'd0) begin
			tgt = POS_W'(1);
		end else begin
			tgt = position - 1'b1;
		end
	end

	// Operation decode against the current count
	always_comb begin
		cmd.start  = req_valid && !req_stall;
		cmd.ch     = char_value;
		cmd.job    = JOB_NONE;
		cmd.idx    = '0;
		cmd.status = ST_OK;
		unique case (operation)
			OP_INSERT: begin
				if (cur_count == DEPTH_CNT) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.job = JOB_INSERT;
					if ((cur_count == '0) || (position == 8'd1)) begin
						cmd.idx = '0;
					end else if (tgt > cur_count) begin
						cmd.idx = cur_count;
					end else begin
						cmd.idx = tgt;
					end
				end
			end
			OP_REMOVE: begin
				if (cur_count == '0) begin
					cmd.status = ST_EMPTY;
				end else if (tgt >= cur_count) begin
					cmd.status = ST_MISSING;
				end else begin
					cmd.job = JOB_REMOVE;
					cmd.idx = tgt;
				end
			end
			OP_CLEAR: cmd.job = JOB_CLEAR;
			default:  cmd.job = JOB_NONE;
		endcase
	end

	pcl_engine #(
		.DEPTH(DEPTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.out_free (out_free),
		.rsp      (rsp)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp.done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.done) begin
			removed_q <= rsp.removed;
			status_q  <= rsp.status;
			count_q   <= rsp.count;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign removed_char = removed_q;
	assign status       = status_q;
	assign entry_count  = count_q;

	// Checks
	`PCL_ASSERT_IMP(a_count_bound, clk, arst_n, rsp_valid, entry_count <= DEPTH_CNT)
	`PCL_ASSERT_IMP(a_full_count, clk, arst_n, rsp_valid && (status == ST_FULL), entry_count == DEPTH_CNT)
	`PCL_ASSERT_IMP(a_empty_count, clk, arst_n, rsp_valid && (status == ST_EMPTY), entry_count == 8'd0)
	`PCL_ASSERT_IMP(a_removed_ok, clk, arst_n, rsp_valid && (removed_char != 8'd0), status == ST_OK)

endmodule

>>> src/pcl_engine.sv
// Shift sequencer and entry memory for the positional character list unit.
module pcl_engine import pcl_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic     clk,
	input  logic     arst_n,
	input  pcl_cmd_t cmd,
	input  logic     out_free,
	output pcl_rsp_t rsp
);

	logic [7:0]    mem [DEPTH];

	pcl_state_t    state_q, state_nxt;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [IW-1:0] idx_q;
	logic [7:0]    ch_q;
	logic [1:0]    status_q;
	logic [7:0]    removed_q;
	logic          pend_q;
	logic [IW-1:0] pend_addr_q;
	logic [7:0]    rdata_q;

	logic [CW-1:0] ptr_dec;
	logic [CW-1:0] idx_ext;
	logic          ins_more;
	logic          rem_more;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          we;
	logic [IW-1:0] wa;
	logic [7:0]    wd;

	assign ptr_dec  = ptr_q - 1'b1;
	assign idx_ext  = CW'(idx_q);
	assign ins_more = (ptr_q > idx_ext);
	assign rem_more = (ptr_q < count_q);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					unique case (cmd.job)
						JOB_INSERT: state_nxt = S_INS;
						JOB_REMOVE: state_nxt = S_REM_RD;
						default:    state_nxt = S_DONE;
					endcase
				end
			end
			S_INS:      state_nxt = ins_more ? S_INS : S_PUT;
			S_PUT:      state_nxt = S_DONE;
			S_REM_RD:   state_nxt = S_REM_GRAB;
			S_REM_GRAB: state_nxt = S_REM;
			S_REM:      state_nxt = rem_more ? S_REM : S_DONE;
			S_DONE:     state_nxt = out_free ? S_IDLE : S_DONE;
			default:    state_nxt = S_IDLE;
		endcase
	end

	// Memory port controls and result
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		unique case (state_q)
			S_INS: begin
				rd_en   = ins_more;
				rd_addr = ptr_dec[IW-1:0];
			end
			S_REM_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
			end
			S_REM: begin
				rd_en   = rem_more;
				rd_addr = ptr_q[IW-1:0];
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = idx_q;
			end
		endcase
		// the pending shift write and the final insert write never coincide
		we = pend_q || (state_q == S_PUT);
		wa = pend_q ? pend_addr_q : idx_q;
		wd = pend_q ? rdata_q : ch_q;

		rsp.idle    = (state_q == S_IDLE);
		rsp.done    = (state_q == S_DONE) && out_free;
		rsp.removed = removed_q;
		rsp.status  = status_q;
		rsp.count   = POS_W'(count_q);
	end

	// Entry memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			pend_q  <= rd_en && ((state_q == S_INS) || (state_q == S_REM));
			if ((state_q == S_IDLE) && cmd.start && (cmd.job == JOB_CLEAR)) begin
				count_q <= '0;
			end else if (state_q == S_PUT) begin
				count_q <= count_q + 1'b1;
			end else if ((state_q == S_REM) && !rem_more) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Item payload and walk pointer
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && cmd.start) begin
			idx_q     <= cmd.idx[IW-1:0];
			ch_q      <= cmd.ch;
			status_q  <= cmd.status;
			removed_q <= '0;
			ptr_q     <= count_q;
		end
		// insert walks down from the top, remove walks up from the gap
		if ((state_q == S_INS) && ins_more) begin
			ptr_q       <= ptr_dec;
			pend_addr_q <= ptr_q[IW-1:0];
		end
		if (state_q == S_REM_GRAB) begin
			removed_q <= rdata_q;
			ptr_q     <= idx_ext + 1'b1;
		end
		if ((state_q == S_REM) && rem_more) begin
			ptr_q       <= ptr_q + 1'b1;
			pend_addr_q <= ptr_dec[IW-1:0];
		end
	end

endmodule

>>> tb/pcl_list_checker.sv
// Checker for the positional character list unit: predicts every result and compares it.
module pcl_list_checker import pcl_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_stall,
	input  logic [1:0] operation,
	input  logic [7:0] char_value,
	input  logic [7:0] position,
	input  logic       rsp_valid,
	input  logic       rsp_stall,
	input  logic [7:0] removed_char,
	input  logic [1:0] status,
	input  logic [7:0] entry_count,
	output int         errors,
	output int         pending
);

	typedef struct packed {
		logic [7:0] removed;
		logic [1:0] status;
		logic [7:0] count;
	} list_result_t;

	// Shadow copy of the list, packed from index 0
	logic [7:0]   shadow_bytes [DEPTH];
	int           shadow_len;
	list_result_t result_q [$];
	int           err_cnt;

	// Apply one item to the shadow list and return the result it should give
	function automatic list_result_t apply_item(input logic [1:0] op, input logic [7:0] ch,
			input logic [7:0] pos);
		list_result_t r;
		int slot;
		r = '0;
		r.status = ST_OK;
		// position 1 is the head, position 0 behaves like position 2
		slot = (pos == 8'd1) ? 0 : (pos == 8'd0) ? 1 : int'(pos) - 1;
		case (op)
			OP_INSERT: begin
				if (shadow_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (shadow_len == 0)
						slot = 0;
					if (slot > shadow_len)
						slot = shadow_len;
					for (int i = shadow_len; i > slot; i--)
						shadow_bytes[i] = shadow_bytes[i - 1];
					shadow_bytes[slot] = ch;
					shadow_len++;
				end
			end
			OP_REMOVE: begin
				if (shadow_len == 0) begin
					r.status = ST_EMPTY;
				end else if (slot >= shadow_len) begin
					r.status = ST_MISSING;
				end else begin
					r.removed = shadow_bytes[slot];
					for (int i = slot; i + 1 < shadow_len; i++)
						shadow_bytes[i] = shadow_bytes[i + 1];
					shadow_len--;
				end
			end
			OP_CLEAR: begin
				shadow_len = 0;
			end
			default: ;
		endcase
		r.count = 8'(shadow_len);
		return r;
	endfunction

	// Results are checked before the same edge's request is predicted
	always @(posedge clk or negedge arst_n) begin : monitor
		list_result_t want;
		if (!arst_n) begin
			result_q.delete();
			shadow_len = 0;
			err_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (result_q.size() == 0) begin
					$error("result with none expected: removed_char %0h status %0d entry_count %0d",
						removed_char, status, entry_count);
					err_cnt++;
				end else begin
					want = result_q.pop_front();
					if (removed_char !== want.removed) begin
						$error("removed_char: expected %0h, got %0h", want.removed, removed_char);
						err_cnt++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						err_cnt++;
					end
					if (entry_count !== want.count) begin
						$error("entry_count: expected %0d, got %0d", want.count, entry_count);
						err_cnt++;
					end
				end
			end
			if (req_valid && !req_stall)
				result_q.push_back(apply_item(operation, char_value, position));
			errors <= err_cnt;
			pending <= result_q.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the list unit testbench: clock, reset, request stimulus, result stalls and verdict.
module testbench import pcl_pkg::*; ();

	localparam int         DEPTH        = 16;
	localparam int         RANDOM_ITEMS = 1525;
	localparam int         CYCLE_LIMIT  = 800_000;
	localparam int         LONG_HOLD    = 300;
	localparam int         DRAIN_CYCLES = 64;
	// Code with no operation behind it
	localparam logic [1:0] OP_UNUSED    = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [1:0] operation = OP_CLEAR;
	logic [7:0] char_value = 8'd0;
	logic [7:0] position = 8'd0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	logic [7:0] removed_char;
	logic [1:0] status;
	logic [7:0] entry_count;
	int         errors;
	int         pending;

	// Handshake between the sender and the receiver for the long hold-off
	bit         long_hold_req = 1'b0;
	bit         hold_active = 1'b0;

	positional_char_list_unit #(.DEPTH(DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.operation    (operation),
		.char_value   (char_value),
		.position     (position),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.removed_char (removed_char),
		.status       (status),
		.entry_count  (entry_count)
	);

	pcl_list_checker #(.DEPTH(DEPTH)) list_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.operation    (operation),
		.char_value   (char_value),
		.position     (position),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.removed_char (removed_char),
		.status       (status),
		.entry_count  (entry_count),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one item and hold it until the block takes it; valid stays high
	task automatic send_item(input logic [1:0] op, input logic [7:0] ch, input logic [7:0] pos);
		req_valid <= 1'b1;
		operation <= op;
		char_value <= ch;
		position <= pos;
		do @(posedge clk); while (req_stall);
	endtask

	// Stop offering and wait until every predicted result has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Request side: directed items, then bursts of random items
	initial begin : stimulus
		int         burst_left;
		int         phase_left;
		int         pick;
		bit         fill_phase;
		logic [1:0] op;
		logic [7:0] pos;
		burst_left = 0;
		phase_left = 0;
		fill_phase = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list, unused code, zero byte in and out
		send_item(OP_REMOVE, 8'h3C, 8'd1);
		send_item(OP_UNUSED, 8'hFF, 8'hFF);
		send_item(OP_INSERT, 8'h00, 8'd0);
		send_item(OP_REMOVE, 8'hFF, 8'd1);
		// Fill to the top with head, zero, far and exact positions
		for (int k = 0; k < DEPTH; k++) begin
			case (k % 4)
				0: pos = 8'd1;
				1: pos = 8'd0;
				2: pos = 8'd255;
				default: pos = 8'(k);
			endcase
			send_item(OP_INSERT, (k == 0) ? 8'hFF : 8'($urandom), pos);
		end
		// Full list, beyond the end, last entry, zero position, clear
		send_item(OP_INSERT, 8'h81, 8'd2);
		send_item(OP_REMOVE, 8'h00, 8'd255);
		send_item(OP_REMOVE, 8'h00, 8'(DEPTH));
		send_item(OP_REMOVE, 8'h00, 8'd0);
		send_item(OP_CLEAR, 8'hA5, 8'd7);
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 700)
				wait_drained();
			// Long receiver hold-off while items keep coming back to back
			if (n == 400) begin
				req_valid <= 1'b0;
				long_hold_req = 1'b1;
				do @(posedge clk); while (!hold_active);
				burst_left = 60;
			end
			if (burst_left == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
					: $urandom_range(1, 15);
			end
			burst_left--;
			// Alternate between growing the list and draining it
			if (phase_left == 0) begin
				fill_phase = ~fill_phase;
				phase_left = $urandom_range(30, 90);
			end
			phase_left--;
			pick = $urandom_range(0, 99);
			if (pick < 1)
				op = OP_CLEAR;
			else if (pick < 3)
				op = OP_UNUSED;
			else if (pick < (fill_phase ? 75 : 30))
				op = OP_INSERT;
			else
				op = OP_REMOVE;
			pos = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 18)) : 8'($urandom);
			send_item(op, 8'($urandom), pos);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Result side: runs of stall patterns, plus one long hold-off on request
	initial begin : receiver
		int mode;
		int run_len;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_active = 1'b1;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_active = 1'b0;
			end
			mode = $urandom_range(0, 3);
			run_len = $urandom_range(8, 60);
			for (int k = 0; k < run_len; k++) begin
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 9) < 3);
					2: rsp_stall <= ($urandom_range(0, 9) < 7);
					default: rsp_stall <= k[0];
				endcase
				@(posedge clk);
			end
		end
	end

	// Timeout
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

endmodule
